// File: rtl/jfr_pkg.sv
// ----------------------------------------------------------------------------
// jfr_pkg
// Types, constants and the message classifier shared by the frame receiver.
// ----------------------------------------------------------------------------
package jfr_pkg;

	localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
	localparam logic [7:0]  ESC_BYTE    = 8'h7D;
	localparam logic [7:0]  ESC_TO_ESC  = 8'h01;
	localparam logic [7:0]  ESC_TO_FLAG = 8'h02;
	localparam logic [16:0] HDR_CHECK   = 17'd13;
	localparam logic [15:0] BODY_START  = 16'd12;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

	localparam logic [15:0] IDX_ID_HI     = 16'd0;
	localparam logic [15:0] IDX_ID_LO     = 16'd1;
	localparam logic [15:0] IDX_LEN_HI    = 16'd2;
	localparam logic [15:0] IDX_LEN_LO    = 16'd3;
	localparam logic [15:0] IDX_SERIAL_HI = 16'd10;
	localparam logic [15:0] IDX_SERIAL_LO = 16'd11;

	localparam logic [15:0] ID_GEN_ANSWER = 16'h8001;
	localparam logic [15:0] ID_REG_ANSWER = 16'h8100;
	localparam logic [15:0] ID_SET_CFG    = 16'h8103;
	localparam logic [15:0] ID_READ_CFG   = 16'h8104;
	localparam logic [15:0] ID_LOC_QUERY  = 16'h8201;
	localparam logic [15:0] ID_TEXT       = 16'h8300;

	localparam int TDATA_W = 64;
	localparam int TUSER_W = 2;

	typedef enum logic [1:0] {
		KIND_BODY    = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_LEN_ERR = 2'd2,
		KIND_SUM_ERR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ACT_GEN_ANSWER = 3'd0,
		ACT_REG_ANSWER = 3'd1,
		ACT_SET_CFG    = 3'd2,
		ACT_READ_CFG   = 3'd3,
		ACT_LOC_QUERY  = 3'd4,
		ACT_TEXT       = 3'd5,
		ACT_UNSUP_ACK  = 3'd6,
		ACT_UNSUP      = 3'd7
	} action_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  body_byte;
		logic [15:0] message_id;
		logic [15:0] serial_number;
		logic [15:0] body_length;
		action_t     action;
		logic        send_ack;
	} result_t;

	function automatic action_t classify(input logic [15:0] id);
		action_t a;
		case (id)
			ID_GEN_ANSWER: a = ACT_GEN_ANSWER;
			ID_REG_ANSWER: a = ACT_REG_ANSWER;
			ID_SET_CFG:    a = ACT_SET_CFG;
			ID_READ_CFG:   a = ACT_READ_CFG;
			ID_LOC_QUERY:  a = ACT_LOC_QUERY;
			ID_TEXT:       a = ACT_TEXT;
			default:       a = id[15] ? ACT_UNSUP_ACK : ACT_UNSUP;
		endcase
		return a;
	endfunction

	function automatic logic needs_ack(input action_t a);
		return (a == ACT_SET_CFG) || (a == ACT_TEXT) || (a == ACT_UNSUP_ACK);
	endfunction

endpackage

// File: rtl/jfr_deframe.sv
// ----------------------------------------------------------------------------
// jfr_deframe
// Frame state, unescape, header capture, checksum and status decision for
// one registered byte per step.
// ----------------------------------------------------------------------------
module jfr_deframe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      byte_in,
	output logic            res_valid,
	output jfr_pkg::result_t res
);
	import jfr_pkg::*;

	logic        in_frame_q, esc_q;
	logic [15:0] count_q, id_q, len_q, serial_q;
	logic [7:0]  xor_q;

	logic        in_frame_d, esc_d;
	logic [15:0] count_d, id_d, len_d, serial_d;
	logic [7:0]  xor_d;
	logic [7:0]  b;
	logic [15:0] body_idx;
	action_t     act;

	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		count_d    = count_q;
		xor_d      = xor_q;
		id_d       = id_q;
		len_d      = len_q;
		serial_d   = serial_q;
		b          = byte_in;
		body_idx   = count_q - BODY_START;
		act        = classify(id_q);
		res_valid  = 1'b0;
		res        = '{kind: KIND_BODY, body_byte: 8'd0, message_id: id_q,
			serial_number: serial_q, body_length: len_q,
			action: ACT_GEN_ANSWER, send_ack: 1'b0};

		if (!in_frame_q) begin
			if (byte_in == FLAG_BYTE) begin
				in_frame_d = 1'b1;
				esc_d      = 1'b0;
				count_d    = '0;
				xor_d      = '0;
				id_d       = '0;
				len_d      = '0;
				serial_d   = '0;
			end
		end else if (byte_in == FLAG_BYTE) begin
			esc_d = 1'b0;
			if (count_q != '0) begin
				res_valid  = 1'b1;
				res.action = ACT_UNSUP;
				if ({1'b0, count_q} != {1'b0, len_q} + HDR_CHECK) begin
					res.kind = KIND_LEN_ERR;
				end else if (xor_q != '0) begin
					res.kind = KIND_SUM_ERR;
				end else begin
					res.kind     = KIND_GOOD;
					res.action   = act;
					res.send_ack = needs_ack(act);
				end
				if (res.kind == KIND_GOOD) begin
					in_frame_d = 1'b0;
				end else begin
					count_d  = '0;
					xor_d    = '0;
					id_d     = '0;
					len_d    = '0;
					serial_d = '0;
				end
			end
		end else if (!esc_q && byte_in == ESC_BYTE) begin
			esc_d = 1'b1;
		end else begin
			if (esc_q) begin
				esc_d = 1'b0;
				if (byte_in == ESC_TO_ESC) begin
					b = ESC_BYTE;
				end else if (byte_in == ESC_TO_FLAG) begin
					b = FLAG_BYTE;
				end
			end
			xor_d = xor_q ^ b;
			if (count_q != COUNT_MAX) begin
				count_d = count_q + 16'd1;
				case (count_q)
					IDX_ID_HI:     id_d     = {b, id_q[7:0]};
					IDX_ID_LO:     id_d     = {id_q[15:8], b};
					IDX_LEN_HI:    len_d    = {b, len_q[7:0]};
					IDX_LEN_LO:    len_d    = {len_q[15:8], b};
					IDX_SERIAL_HI: serial_d = {b, serial_q[7:0]};
					IDX_SERIAL_LO: serial_d = {serial_q[15:8], b};
					default: ;
				endcase
				if (count_q >= BODY_START && body_idx < len_q) begin
					res_valid     = 1'b1;
					res.body_byte = b;
				end
			end
		end
		res_valid = res_valid && step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			count_q    <= '0;
			xor_q      <= '0;
			id_q       <= '0;
			len_q      <= '0;
			serial_q   <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			count_q    <= count_d;
			xor_q      <= xor_d;
			id_q       <= id_d;
			len_q      <= len_d;
			serial_q   <= serial_d;
		end
	end

endmodule

// File: rtl/jfr_out_buf.sv
// ----------------------------------------------------------------------------
// jfr_out_buf
// Two-entry result register that keeps the result side apart from the byte
// path, so a waiting result does not stall the next item.
// ----------------------------------------------------------------------------
module jfr_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jfr_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_ready,
	output jfr_pkg::result_t out_data
);
	import jfr_pkg::*;

	result_t    mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full      = cnt_q[1];
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/jt808_frame_receiver.sv
// ----------------------------------------------------------------------------
// jt808_frame_receiver
// Deframes JT/T808 messages from a byte stream: unescape, header capture,
// body byte output and a status item at each closing flag.
// ----------------------------------------------------------------------------
// Takes one link byte per cycle while the output buffer has room, and can give
// one result item per cycle. A byte lands in the input register, is decoded
// combinationally against the frame state and its result is written into a
// two-entry output buffer, from which it is offered on the output.
// Input is held off only while the output buffer is full. Body bytes are
// emitted as they arrive; a frame that closes with a length or checksum
// error has already sent its body bytes, which the consumer must discard,
// and its closing flag opens the next frame directly.
module jt808_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // in_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// body_byte, message_id, serial_number, body_length, action, send_ack, zero pad
	output logic [jfr_pkg::TDATA_W-1:0]   m_axis_tdata,
	output logic [jfr_pkg::TUSER_W-1:0]   m_axis_tuser   // kind
);
	import jfr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step, full, res_valid;
	result_t    res, out_res;

	assign step          = valid_s1 && !full;
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	jfr_deframe u_deframe (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	jfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tuser = out_res.kind;
	assign m_axis_tdata = {4'd0, out_res.send_ack, out_res.action, out_res.body_length,
		out_res.serial_number, out_res.message_id, out_res.body_byte};

endmodule

// File: rtl/jfr_checker.sv
// ----------------------------------------------------------------------------
// jfr_checker
// Port-level checks on the frame receiver's result stream.
// ----------------------------------------------------------------------------
module jfr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [jfr_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic [jfr_pkg::TUSER_W-1:0] m_axis_tuser
);
	import jfr_pkg::*;

	logic [2:0] act;
	logic       ack;

	assign act = m_axis_tdata[58:56];
	assign ack = m_axis_tdata[59];

	a_rst_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	a_body_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_BODY |-> act == ACT_GEN_ANSWER && !ack)
		else $error("body item carries action or ack");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_LEN_ERR || m_axis_tuser == KIND_SUM_ERR)
		|-> act == ACT_UNSUP && !ack && m_axis_tdata[7:0] == 8'd0)
		else $error("error status with bad fields");

	a_ack_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ack |-> m_axis_tuser == KIND_GOOD
		&& (act == ACT_SET_CFG || act == ACT_TEXT || act == ACT_UNSUP_ACK))
		else $error("ack on a frame class that takes none");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
		&& $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind jt808_frame_receiver jfr_checker u_jfr_checker (.*);
